// ===== rtl/assert_macros.svh =====
// Assertion macros used by the timer top level.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define ITC_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ITC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/itc_pkg.sv =====
// Package for the interval timer counter: item types and code constants.
// Depends on nothing; used by all timer modules and the verification files.
package itc_pkg;

    // Item actions
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // Bus port select
    localparam logic PORT_DATA = 1'b0;
    localparam logic PORT_CTRL = 1'b1;

    // Control word fields
    localparam logic [1:0] SEL_CNT0      = 2'b00;
    localparam logic [1:0] RW_LATCH      = 2'b00;
    localparam logic [2:0] MODE_RATE     = 3'd2;
    localparam logic [2:0] MODE_RATE_ALT = 3'd6;

    typedef struct packed {
        logic [1:0] action;
        logic       port_select;
        logic [7:0] write_data;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       out_level;
        logic       out_rose;
    } t_result;

endpackage

// ===== rtl/itc_if.sv =====
// Valid/ready channel interfaces for timer items and results.
// Depends on nothing; widths follow the timer item fields.
interface itc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic       port_select;
    logic [7:0] write_data;

    modport source (output valid, output action, output port_select,
                    output write_data, input ready);
    modport sink   (input valid, input action, input port_select,
                    input write_data, output ready);
endinterface

interface itc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       out_level;
    logic       out_rose;

    modport source (output valid, output read_data, output out_level,
                    output out_rose, input ready);
    modport sink   (input valid, input read_data, input out_level,
                    input out_rose, output ready);
endinterface

// ===== rtl/itc_in_stage.sv =====
// Input register of the timer: captures one item per transfer.
// Depends on itc_pkg and itc_in_if.
module itc_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    itc_in_if.sink         i_in,
    input  logic           i_adv,
    output logic           o_valid,
    output itc_pkg::t_item o_item
);

    logic           r_valid;
    itc_pkg::t_item r_item;
    logic           w_accept;

    // Free when empty or when the held item moves on this cycle
    assign i_in.ready = !r_valid || i_adv;
    assign w_accept   = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_adv) begin
            r_valid <= w_accept;
        end
    end

    // Payload capture, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.action      <= i_in.action;
            r_item.port_select <= i_in.port_select;
            r_item.write_data  <= i_in.write_data;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/itc_core.sv =====
// Counter 0 state and its single-pass next-state logic.
// Depends on itc_pkg.
module itc_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  itc_pkg::t_item   i_item,
    output itc_pkg::t_result o_result
);

    logic [15:0] r_count, n_count;
    logic [15:0] r_reload, n_reload;
    logic [15:0] r_latch, n_latch;
    logic        r_latch_full, n_latch_full;
    logic        r_write_high, n_write_high;
    logic        r_read_high, n_read_high;
    logic        r_periodic, n_periodic;
    logic        r_load_pend, n_load_pend;
    logic        r_running, n_running;
    logic        r_line, n_line;

    logic [15:0] w_dec;
    logic [15:0] w_rd_src;
    logic [7:0]  w_rd;
    logic [1:0]  w_sel;
    logic [1:0]  w_rw;
    logic [2:0]  w_mode;
    logic        w_mode_per;

    assign w_dec      = r_count - 16'd1;
    assign w_rd_src   = r_latch_full ? r_latch : r_count;
    assign w_sel      = i_item.write_data[7:6];
    assign w_rw       = i_item.write_data[5:4];
    assign w_mode     = i_item.write_data[3:1];
    assign w_mode_per = (w_mode inside {itc_pkg::MODE_RATE, itc_pkg::MODE_RATE_ALT});

    // Next state for one item
    always_comb begin
        n_count      = r_count;
        n_reload     = r_reload;
        n_latch      = r_latch;
        n_latch_full = r_latch_full;
        n_write_high = r_write_high;
        n_read_high  = r_read_high;
        n_periodic   = r_periodic;
        n_load_pend  = r_load_pend;
        n_running    = r_running;
        n_line       = r_line;
        w_rd         = 8'd0;
        case (i_item.action)
            itc_pkg::ACT_TICK: begin
                if (r_load_pend) begin
                    n_count     = r_reload;
                    n_load_pend = 1'b0;
                    n_running   = 1'b1;
                end else if (r_running) begin
                    n_count = w_dec;
                    if (r_periodic) begin
                        // reload at terminal count, low pulse on count of one
                        if (w_dec == 16'd0) begin
                            n_count = r_reload;
                            n_line  = 1'b1;
                        end else if (w_dec == 16'd1) begin
                            n_line = 1'b0;
                        end
                    end else if (w_dec == 16'd0) begin
                        n_line = 1'b1;
                    end
                end
            end
            itc_pkg::ACT_WRITE: begin
                if (i_item.port_select == itc_pkg::PORT_CTRL) begin
                    if (w_sel == itc_pkg::SEL_CNT0) begin
                        if (w_rw == itc_pkg::RW_LATCH) begin
                            // keep the first latched value
                            if (!r_latch_full) begin
                                n_latch      = r_count;
                                n_latch_full = 1'b1;
                            end
                        end else begin
                            n_periodic   = w_mode_per;
                            n_running    = 1'b0;
                            n_load_pend  = 1'b0;
                            n_write_high = 1'b0;
                            n_read_high  = 1'b0;
                            n_latch_full = 1'b0;
                            n_line       = w_mode_per;
                        end
                    end
                end else if (!r_write_high) begin
                    n_reload     = {r_reload[15:8], i_item.write_data};
                    n_write_high = 1'b1;
                    if (!r_periodic) begin
                        n_running = 1'b0;
                        n_line    = 1'b0;
                    end
                end else begin
                    n_reload     = {i_item.write_data, r_reload[7:0]};
                    n_write_high = 1'b0;
                    n_load_pend  = 1'b1;
                end
            end
            itc_pkg::ACT_READ: begin
                if (i_item.port_select == itc_pkg::PORT_DATA) begin
                    if (r_read_high) begin
                        w_rd         = w_rd_src[15:8];
                        n_latch_full = 1'b0;
                    end else begin
                        w_rd = w_rd_src[7:0];
                    end
                    n_read_high = !r_read_high;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= 16'd0;
            r_reload     <= 16'd0;
            r_latch      <= 16'd0;
            r_latch_full <= 1'b0;
            r_write_high <= 1'b0;
            r_read_high  <= 1'b0;
            r_periodic   <= 1'b0;
            r_load_pend  <= 1'b0;
            r_running    <= 1'b0;
            r_line       <= 1'b0;
        end else if (i_en) begin
            r_count      <= n_count;
            r_reload     <= n_reload;
            r_latch      <= n_latch;
            r_latch_full <= n_latch_full;
            r_write_high <= n_write_high;
            r_read_high  <= n_read_high;
            r_periodic   <= n_periodic;
            r_load_pend  <= n_load_pend;
            r_running    <= n_running;
            r_line       <= n_line;
        end
    end

    // Rise is reported only for ticks; a mode set that raises the line is not an interrupt
    assign o_result.read_data = w_rd;
    assign o_result.out_level = n_line;
    assign o_result.out_rose  = (i_item.action == itc_pkg::ACT_TICK) && n_line && !r_line;

endmodule

// ===== rtl/itc_out_stage.sv =====
// Result register of the timer, driving the output channel.
// Depends on itc_pkg and itc_out_if.
module itc_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  itc_pkg::t_result i_result,
    output logic             o_can_take,
    itc_out_if.source        o_out
);

    logic             r_valid;
    itc_pkg::t_result r_result;

    // Room when empty or when the held result transfers now
    assign o_can_take = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_take && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.read_data = r_result.read_data;
    assign o_out.out_level = r_result.out_level;
    assign o_out.out_rose  = r_result.out_rose;

endmodule

// ===== rtl/interval_timer_counter_unit.sv =====
// Top level of the 8254-style counter 0: input register, core, result register.
// Depends on itc_pkg, itc_if, itc_in_stage, itc_core, itc_out_stage, assert_macros.svh.
//
// Usage:
//   i_in carries one item per transfer: a timer tick, a bus write or a bus
//   read (action, port_select, write_data). o_out returns exactly one result
//   per item in order: read_data, out_level and out_rose.
//   Path: an item waits in the input register, passes the core combinationally
//   and is captured in the result register, which holds it until it transfers out.
//   Throughput: one item per cycle while o_out.ready is high; the count, reload
//   and byte-order state updates in the single pass between the two registers,
//   so the next item sees it without a bubble.
//   Reset (i_rst_n low, synchronous): all counter state clears to zero, the
//   output line is low and both registers are empty.
//   Receiver stall: the result register holds its result while o_out.ready is
//   low; the input register still takes one more item, then i_in.ready drops
//   until the result transfers.
`include "assert_macros.svh"

module interval_timer_counter_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    itc_in_if.sink    i_in,
    itc_out_if.source o_out
);

    logic             w_in_valid;
    itc_pkg::t_item   w_item;
    logic             w_adv;
    logic             w_core_en;
    itc_pkg::t_result w_result;

    itc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_adv   (w_adv),
        .o_valid (w_in_valid),
        .o_item  (w_item)
    );

    // State moves only when the held item goes into the result register
    assign w_core_en = w_in_valid && w_adv;

    itc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_core_en),
        .i_item   (w_item),
        .o_result (w_result)
    );

    itc_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_in_valid),
        .i_result   (w_result),
        .o_can_take (w_adv),
        .o_out      (o_out)
    );

    // Checks
    `ITC_ASSERT_RST(a_no_take_when_full, i_clk, i_rst_n, (w_in_valid && o_out.valid && !o_out.ready) |-> !i_in.ready, "input taken while both stages are full")
    `ITC_ASSERT_RST(a_rd_only_on_read, i_clk, i_rst_n, (w_core_en && (w_item.action != itc_pkg::ACT_READ)) |-> (w_result.read_data == 8'd0), "read data nonzero on a non-read item")
    `ITC_ASSERT_RST(a_rose_only_on_tick, i_clk, i_rst_n, (w_core_en && w_result.out_rose) |-> (w_item.action == itc_pkg::ACT_TICK), "output rose outside a tick")
    `ITC_ASSERT_ALWAYS(a_rose_sets_level, i_clk, (o_out.valid && o_out.out_rose) |-> o_out.out_level, "rise flagged with line low")

endmodule

// ===== verif/itc_result_checker.sv =====
// Result checker for the 8254-style counter 0: predicts each result from the accepted items.
// Depends on itc_pkg and the itc_in_if / itc_out_if channel interfaces.
module itc_result_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    itc_in_if    in_ch,
    itc_out_if   out_ch,
    output int   o_fail_count,
    output int   o_pending
);

    // Predicted counter state
    logic [15:0] cnt;
    logic [15:0] reload;
    logic [15:0] latch_val;
    logic        latch_held;
    logic        wr_hi;
    logic        rd_hi;
    logic        periodic;
    logic        load_wait;
    logic        counting;
    logic        timer_line;

    itc_pkg::t_result timer_results_q[$];
    itc_pkg::t_item   seen_item;
    itc_pkg::t_result want;

    // Apply one item to the predicted state and return the result it gives
    function automatic itc_pkg::t_result timer_step(input itc_pkg::t_item it);
        itc_pkg::t_result r;
        logic        line_was;
        logic [1:0]  sel;
        logic [1:0]  rw;
        logic [2:0]  mode;
        logic [15:0] v;
        r   = '0;
        sel = it.write_data[7:6];
        rw  = it.write_data[5:4];
        mode = it.write_data[3:1];
        case (it.action)
            itc_pkg::ACT_TICK: begin
                line_was = timer_line;
                if (load_wait) begin
                    cnt       = reload;
                    load_wait = 1'b0;
                    counting  = 1'b1;
                end else if (counting) begin
                    cnt = cnt - 16'd1;
                    if (periodic) begin
                        // reload at zero, output low for the tick at one
                        if (cnt == 16'd0) begin
                            cnt        = reload;
                            timer_line = 1'b1;
                        end else if (cnt == 16'd1) begin
                            timer_line = 1'b0;
                        end
                    end else if (cnt == 16'd0) begin
                        timer_line = 1'b1;
                    end
                end
                r.out_rose = timer_line & ~line_was;
            end
            itc_pkg::ACT_WRITE: begin
                if (it.port_select == itc_pkg::PORT_CTRL) begin
                    if (sel == itc_pkg::SEL_CNT0) begin
                        if (rw == itc_pkg::RW_LATCH) begin
                            // a second latch keeps the first value
                            if (!latch_held) begin
                                latch_val  = cnt;
                                latch_held = 1'b1;
                            end
                        end else begin
                            periodic   = (mode == itc_pkg::MODE_RATE) ||
                                         (mode == itc_pkg::MODE_RATE_ALT);
                            counting   = 1'b0;
                            load_wait  = 1'b0;
                            wr_hi      = 1'b0;
                            rd_hi      = 1'b0;
                            latch_held = 1'b0;
                            timer_line = periodic;
                        end
                    end
                end else if (!wr_hi) begin
                    reload[7:0] = it.write_data;
                    wr_hi       = 1'b1;
                    // one-shot stops on a low-byte write
                    if (!periodic) begin
                        counting   = 1'b0;
                        timer_line = 1'b0;
                    end
                end else begin
                    reload[15:8] = it.write_data;
                    wr_hi        = 1'b0;
                    load_wait    = 1'b1;
                end
            end
            itc_pkg::ACT_READ: begin
                if (it.port_select == itc_pkg::PORT_DATA) begin
                    v = latch_held ? latch_val : cnt;
                    if (rd_hi) begin
                        r.read_data = v[15:8];
                        latch_held  = 1'b0;
                    end else begin
                        r.read_data = v[7:0];
                    end
                    rd_hi = ~rd_hi;
                end
            end
            default: ;
        endcase
        r.out_level = timer_line;
        return r;
    endfunction

    task automatic check_field(input string fname, input int exp_val, input int got_val);
        if (exp_val != got_val) begin
            o_fail_count++;
            $display("%0t: %s expected %0h, got %0h", $time, fname, exp_val, got_val);
        end
    endtask

    // Predict on each item transfer, compare on each result transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cnt          = '0;
            reload       = '0;
            latch_val    = '0;
            latch_held   = 1'b0;
            wr_hi        = 1'b0;
            rd_hi        = 1'b0;
            periodic     = 1'b0;
            load_wait    = 1'b0;
            counting     = 1'b0;
            timer_line   = 1'b0;
            o_fail_count = 0;
            timer_results_q.delete();
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                seen_item.action      = in_ch.action;
                seen_item.port_select = in_ch.port_select;
                seen_item.write_data  = in_ch.write_data;
                timer_results_q.push_back(timer_step(seen_item));
            end
            if (out_ch.valid && out_ch.ready) begin
                if (timer_results_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected result read_data=%0h out_level=%0b out_rose=%0b",
                             $time, out_ch.read_data, out_ch.out_level, out_ch.out_rose);
                end else begin
                    want = timer_results_q.pop_front();
                    check_field("read_data", want.read_data, out_ch.read_data);
                    check_field("out_level", want.out_level, out_ch.out_level);
                    check_field("out_rose", want.out_rose, out_ch.out_rose);
                end
            end
        end
        o_pending = timer_results_q.size();
    end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for interval_timer_counter_unit: clock, reset, item stimulus, verdict.
// Depends on itc_pkg, itc_if, the timer RTL and itc_result_checker.
module tb_top;

    // Codes the package leaves out
    localparam logic [1:0] ACT_NONE     = 2'd3;
    localparam logic [1:0] RW_LSB       = 2'b01;
    localparam logic [1:0] RW_BOTH      = 2'b11;
    localparam logic [1:0] SEL_READBACK = 2'b11;
    localparam logic [2:0] MODE_ONESHOT = 3'd0;
    localparam int         N_ITEMS      = 2000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   sent;
    int   gap_pct;
    int   stall_pct;
    int   next_mark;

    itc_in_if  in_ch();
    itc_out_if out_ch();

    interval_timer_counter_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    itc_result_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: random stall bursts
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(7, 1)) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    // One item transfer, with an optional idle burst before it
    task automatic send(input logic [1:0] act, input logic port, input logic [7:0] data);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(7, 1)) @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.action      <= act;
        in_ch.port_select <= port;
        in_ch.write_data  <= data;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        @(negedge i_clk);
        if (act != ACT_NONE)
            sent++;
    endtask

    task automatic tick(input int n);
        repeat (n) send(itc_pkg::ACT_TICK, itc_pkg::PORT_DATA, 8'($urandom));
    endtask

    task automatic ctrl(input logic [7:0] cw);
        send(itc_pkg::ACT_WRITE, itc_pkg::PORT_CTRL, cw);
    endtask

    task automatic load_reload(input logic [15:0] v);
        send(itc_pkg::ACT_WRITE, itc_pkg::PORT_DATA, v[7:0]);
        send(itc_pkg::ACT_WRITE, itc_pkg::PORT_DATA, v[15:8]);
    endtask

    task automatic read_count();
        send(itc_pkg::ACT_READ, itc_pkg::PORT_DATA, 8'($urandom));
    endtask

    function automatic logic [7:0] mode_word(input logic [1:0] rw, input logic [2:0] mode,
                                             input logic bcd);
        return {itc_pkg::SEL_CNT0, rw, mode, bcd};
    endfunction

    function automatic logic [7:0] latch_word();
        return {itc_pkg::SEL_CNT0, itc_pkg::RW_LATCH, 4'($urandom)};
    endfunction

    // Random reload: mostly short counts so terminal count is reached
    function automatic logic [15:0] pick_reload();
        int r;
        r = $urandom_range(9);
        if (r < 6)
            return 16'($urandom_range(12, 1));
        else if (r < 8)
            return 16'($urandom_range(3));
        else if (r == 8)
            return 16'd0;
        return 16'($urandom);
    endfunction

    // Ticks mixed with reads, latches, control-port reads and the odd reload rewrite
    task automatic run_timer(input int n);
        int k;
        repeat (n) begin
            k = $urandom_range(19);
            if (k < 3)
                read_count();
            else if (k == 3)
                ctrl(latch_word());
            else if (k == 4 && $urandom_range(3) == 0)
                send(itc_pkg::ACT_READ, itc_pkg::PORT_CTRL, 8'($urandom));
            else if (k == 5 && $urandom_range(3) == 0)
                send(itc_pkg::ACT_WRITE, itc_pkg::PORT_DATA, 8'($urandom));
            else
                tick(1);
        end
    endtask

    initial begin
        in_ch.valid       <= 1'b0;
        in_ch.action      <= itc_pkg::ACT_TICK;
        in_ch.port_select <= itc_pkg::PORT_DATA;
        in_ch.write_data  <= '0;
        i_rst_n           <= 1'b0;
        gap_pct   = 0;
        stall_pct = 0;
        sent      = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: idle counter, ignored accesses, one-shot wrap, latch, periodic edges
        tick(1);
        read_count();
        send(itc_pkg::ACT_READ, itc_pkg::PORT_CTRL, 8'hFF);
        send(ACT_NONE, itc_pkg::PORT_CTRL, 8'hFF);
        ctrl({SEL_READBACK, RW_BOTH, itc_pkg::MODE_RATE, 1'b0});
        ctrl(mode_word(RW_BOTH, MODE_ONESHOT, 1'b1));
        load_reload(16'h0003);
        tick(5);
        ctrl(latch_word());
        ctrl(latch_word());
        tick(1);
        read_count();
        read_count();
        ctrl(mode_word(RW_LSB, itc_pkg::MODE_RATE_ALT, 1'b0));
        load_reload(16'h0001);
        tick(3);
        send(itc_pkg::ACT_WRITE, itc_pkg::PORT_DATA, 8'hFF);
        send(itc_pkg::ACT_WRITE, itc_pkg::PORT_DATA, 8'hFF);
        tick(2);
        read_count();

        // Random: mostly well-formed programming sequences, some noise
        next_mark = 0;
        while (sent < N_ITEMS) begin
            if (sent >= N_ITEMS - 300) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else if (sent >= next_mark) begin
                next_mark += 200;
                case ($urandom_range(2))
                    0: begin gap_pct = 0;  stall_pct = 0;  end
                    1: begin gap_pct = 10; stall_pct = 10; end
                    default: begin gap_pct = 35; stall_pct = 35; end
                endcase
            end
            case ($urandom_range(9))
                7, 8: begin
                    repeat ($urandom_range(10, 1))
                        send(2'($urandom), 1'($urandom), 8'($urandom));
                end
                9: begin
                    if ($urandom_range(1))
                        ctrl({2'($urandom_range(3, 1)), 6'($urandom)});
                    else begin
                        ctrl(mode_word(2'($urandom_range(3, 1)), 3'($urandom), 1'($urandom)));
                        send(itc_pkg::ACT_WRITE, itc_pkg::PORT_DATA, 8'($urandom));
                    end
                    run_timer($urandom_range(8, 1));
                end
                default: begin
                    ctrl(mode_word(2'($urandom_range(3, 1)), 3'($urandom), 1'($urandom)));
                    load_reload(pick_reload());
                    run_timer($urandom_range(40, 1));
                end
            endcase
        end

        // Drain
        in_ch.valid <= 1'b0;
        stall_pct = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (5) @(negedge i_clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== interval_timer_counter_unit.f =====
+incdir+rtl
rtl/itc_pkg.sv
rtl/itc_if.sv
rtl/itc_in_stage.sv
rtl/itc_core.sv
rtl/itc_out_stage.sv
rtl/interval_timer_counter_unit.sv
verif/itc_result_checker.sv
verif/tb_top.sv
